### hdl/ltbc_pkg.sv
// Shared types, constants and helpers for the load-record to tape-block converter.
// No dependencies; the parser, queue, sequencer and top level import this package.
`default_nettype none

package ltbc_pkg;

   // tape format marks
   localparam logic [7:0] HDR_SYNC      = 8'h66;
   localparam logic [7:0] HDR_NAME_MARK = 8'h55;
   localparam logic [7:0] LOAD_MARK     = 8'h3C;
   localparam logic [7:0] EXEC_MARK     = 8'h78;
   localparam logic [7:0] SPACE_CHAR    = 8'h20;

   // record stream codes
   localparam logic [7:0] REC_LOAD     = 8'd1;
   localparam logic [7:0] REC_EXEC     = 8'd2;
   localparam logic [7:0] EXEC_LEN     = 8'd2;
   localparam logic [8:0] LOAD_LEN_BIAS = 9'd254;
   localparam logic [8:0] LOAD_LEN_ADJ  = 9'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

   // configuration register indexes
   localparam logic REG_FILE_NAME   = 1'b0;
   localparam logic REG_NAME_LENGTH = 1'b1;

   localparam logic [47:0] FILE_NAME_RESET = 48'h2020_2020_2020;
   localparam int NAME_BYTES     = 6;   // characters held in file_name
   localparam int NAME_CHARS_DEF = 6;
   localparam int NAME_CHARS_MAX = 8;
   localparam int QUEUE_DEPTH    = 4;

   typedef enum logic [1:0] {
      CMD_ONE,   // one result byte
      CMD_TWO,   // two result bytes
      CMD_HDR    // tape header
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [1:0]   status;
   } cmd_type;

   // Name character at position pos: stored character, or space past the used length or the stored bytes.
   function automatic logic [7:0] name_char(input logic [47:0] fname,
                                            input logic [3:0]  used,
                                            input logic [3:0]  pos);
      logic [47:0] shifted;
      shifted = fname >> {pos[2:0], 3'b000};
      if ((pos < used) && (pos < 4'(NAME_BYTES)))
         return shifted[7:0];
      else
         return SPACE_CHAR;
   endfunction

endpackage

`default_nettype wire

### hdl/ltbc_intf.sv
// Valid/ready channel interfaces for the record input and the tape output.
// No dependencies.
`default_nettype none

interface ltbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       new_file;

   modport source (output valid, output in_byte, output new_file, input ready);
   modport sink   (input valid, input in_byte, input new_file, output ready);
endinterface

interface ltbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output out_byte, output status, output last, input ready);
   modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

### hdl/load_record_to_tape_block_converter.sv
// Top level of the load-record to tape-block converter: registers, parser, queue, sequencer.
// Depends on ltbc_pkg, ltbc_intf, ltbc_front, ltbc_queue and ltbc_back.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    in_byte[7:0], new_file
//   rsp_ch    out        valid/ready    out_byte[7:0], status[1:0], last
//   csr_*     in         csr_we only    csr_index (0 file_name, 1 name_length), csr_wdata[47:0]
//
// The parser takes one stream byte per cycle while the command queue has room; the
// sequencer drives one tape byte per cycle through the output register while rsp_ch is
// ready. A record end gives two tape bytes, data and checksum, and a new-file step a
// NAME_CHARS + 2 byte header. Results pass the queue, cur_ff and the output register.
// Reset is synchronous and clears parser state, queue and output; file_name returns to
// six spaces and name_length to zero. A stalled rsp_ch backs up into the queue, then req_ch.
`default_nettype none

module load_record_to_tape_block_converter
   import ltbc_pkg::*;
#(
   parameter int NAME_CHARS = NAME_CHARS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   ltbc_req_if.sink         req_ch,
   ltbc_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [47:0] csr_wdata
);

   logic [47:0] file_name_ff;
   logic [2:0]  name_length_ff;

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   // configuration registers: the user writes them only while the block is idle; the block itself does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         file_name_ff   <= FILE_NAME_RESET;
         name_length_ff <= 3'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FILE_NAME:   file_name_ff   <= csr_wdata;
            REG_NAME_LENGTH: name_length_ff <= csr_wdata[2:0];
            default:         ;
         endcase
      end
   end

   // parse and classify each accepted byte
   ltbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // hold pending commands so either side can stall
   ltbc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   // expand commands into tape bytes
   ltbc_back #(
      .NAME_CHARS (NAME_CHARS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .file_name   (file_name_ff),
      .name_length (name_length_ff),
      .rsp         (rsp_ch)
   );

   // error results carry a zero byte and end their transfer group
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status != STATUS_OK)) |-> (rsp_ch.out_byte == 8'd0 && rsp_ch.last))
      else $error("error result with data or without last");

   // no undefined status code leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.status != 2'd3))
      else $error("undefined status code");

   // nothing is presented straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("result valid after reset");

   // a full queue must stall the input side
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !(req_ch.valid && req_ch.ready))
      else $error("byte accepted into a full queue");

endmodule

`default_nettype wire

### hdl/ltbc_front.sv
// Record parser: accepts stream bytes and turns each into at most one output command.
// Depends on ltbc_pkg and ltbc_req_if.
`default_nettype none

module ltbc_front
   import ltbc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   ltbc_req_if.sink     req,
   input  wire logic    q_full,
   output logic         push,
   output cmd_type      push_cmd
);

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_LEN,
      PH_ALO,
      PH_AHI,
      PH_DATA
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       kind_ff, kind_in;       // 0 load, 1 execution
   logic [8:0] left_ff, left_in;
   logic [7:0] sum_ff, sum_in;
   logic       halted_ff, halted_in;

   logic       accept;
   logic       has_cmd;
   logic [7:0] b;
   logic [7:0] sum_add;
   logic [8:0] left_dec;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign sum_add   = sum_ff + b;
   assign left_dec  = (left_ff != 9'd0) ? left_ff - 9'd1 : left_ff;
   assign push      = accept && has_cmd;

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      halted_in = halted_ff;
      has_cmd   = 1'b0;
      push_cmd  = '{kind: CMD_ONE, b0: 8'd0, b1: 8'd0, status: STATUS_OK};

      if (req.new_file) begin
         phase_in      = PH_TYPE;
         kind_in       = 1'b0;
         left_in       = 9'd0;
         sum_in        = 8'd0;
         halted_in     = 1'b0;
         has_cmd       = 1'b1;
         push_cmd.kind = CMD_HDR;
      end else if (!halted_ff) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (b == REC_LOAD) begin
                  kind_in     = 1'b0;
                  phase_in    = PH_LEN;
                  has_cmd     = 1'b1;
                  push_cmd.b0 = LOAD_MARK;
               end else if (b == REC_EXEC) begin
                  kind_in  = 1'b1;
                  phase_in = PH_LEN;
               end else begin
                  halted_in       = 1'b1;
                  has_cmd         = 1'b1;
                  push_cmd.status = STATUS_BAD_TYPE;
               end
            end
            PH_LEN: begin
               if (!kind_ff) begin
                  left_in     = (b <= 8'd2) ? 9'(b) + LOAD_LEN_BIAS : 9'(b) - LOAD_LEN_ADJ;
                  phase_in    = PH_ALO;
                  has_cmd     = 1'b1;
                  push_cmd.b0 = left_in[7:0];
               end else if (b == EXEC_LEN) begin
                  phase_in = PH_ALO;
               end else begin
                  halted_in       = 1'b1;
                  has_cmd         = 1'b1;
                  push_cmd.status = STATUS_BAD_LEN;
               end
            end
            PH_ALO: begin
               sum_in   = b;
               phase_in = PH_AHI;
               has_cmd  = 1'b1;
               if (kind_ff) begin
                  push_cmd.kind = CMD_TWO;
                  push_cmd.b0   = EXEC_MARK;
                  push_cmd.b1   = b;
               end else begin
                  push_cmd.b0 = b;
               end
            end
            PH_AHI: begin
               sum_in      = sum_add;
               phase_in    = kind_ff ? PH_TYPE : PH_DATA;
               has_cmd     = 1'b1;
               push_cmd.b0 = b;
            end
            PH_DATA: begin
               sum_in      = sum_add;
               left_in     = left_dec;
               has_cmd     = 1'b1;
               push_cmd.b0 = b;
               if (left_dec == 9'd0) begin
                  // last data byte: append the checksum
                  push_cmd.kind = CMD_TWO;
                  push_cmd.b1   = sum_add;
                  phase_in      = PH_TYPE;
               end
            end
            default: begin
               phase_in = PH_TYPE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         kind_ff   <= 1'b0;
         left_ff   <= 9'd0;
         sum_ff    <= 8'd0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

### hdl/ltbc_queue.sv
// Short command queue between the record parser and the byte sequencer.
// Depends on ltbc_pkg.
`default_nettype none

module ltbc_queue
   import ltbc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire cmd_type  push_cmd,
   output logic          full,
   input  wire logic     pop,
   output logic          pop_valid,
   output cmd_type       pop_cmd
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   cmd_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

### hdl/ltbc_back.sv
// Byte sequencer: expands queued commands into tape bytes behind an output register.
// Depends on ltbc_pkg and ltbc_rsp_if.
`default_nettype none

module ltbc_back
   import ltbc_pkg::*;
#(
   parameter int NAME_CHARS = NAME_CHARS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire cmd_type     q_cmd,
   output logic             q_pop,
   input  wire logic [47:0] file_name,
   input  wire logic [2:0]  name_length,
   ltbc_rsp_if.source       rsp
);

   localparam int HdrLen = NAME_CHARS + 2;
   localparam int IdxW   = $clog2(HdrLen);

   cmd_type         cur_ff;
   logic            cur_valid_ff, cur_valid_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff;
   logic [1:0]      status_ff;
   logic            last_ff;

   logic            advance;
   logic            cur_last;
   logic [IdxW-1:0] last_idx;
   logic [3:0]      used;
   logic [3:0]      pos;
   logic [7:0]      cur_byte;

   // characters taken from file_name, capped at NAME_CHARS
   assign used = ({1'b0, name_length} > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : {1'b0, name_length};
   assign pos  = 4'(idx_ff) - 4'd2;

   always_comb begin
      unique case (cur_ff.kind)
         CMD_ONE: last_idx = '0;
         CMD_TWO: last_idx = IdxW'(1);
         CMD_HDR: last_idx = IdxW'(HdrLen - 1);
         default: last_idx = '0;
      endcase
   end

   always_comb begin
      unique case (cur_ff.kind)
         CMD_ONE: cur_byte = cur_ff.b0;
         CMD_TWO: cur_byte = (idx_ff == '0) ? cur_ff.b0 : cur_ff.b1;
         CMD_HDR: begin
            if (idx_ff == '0)
               cur_byte = HDR_SYNC;
            else if (idx_ff == IdxW'(1))
               cur_byte = HDR_NAME_MARK;
            else
               cur_byte = name_char(file_name, used, pos);
         end
         default: cur_byte = cur_ff.b0;
      endcase
   end

   assign cur_last = (idx_ff == last_idx);
   assign advance  = !out_valid_ff || rsp.ready;
   assign q_pop    = q_valid && (!cur_valid_ff || (advance && cur_last));

   always_comb begin
      out_valid_in = out_valid_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (advance)
         out_valid_in = cur_valid_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (advance && cur_valid_ff) begin
         if (cur_last)
            cur_valid_in = 1'b0;
         else
            idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop)
         cur_ff <= q_cmd;
      if (advance && cur_valid_ff) begin
         out_byte_ff <= cur_byte;
         status_ff   <= (cur_ff.kind == CMD_HDR) ? STATUS_OK : cur_ff.status;
         last_ff     <= cur_last;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.status   = status_ff;
   assign rsp.last     = last_ff;

endmodule

`default_nettype wire
